@@ design/prc_pkg.sv @@
package prc_pkg;

  localparam int unsigned InW   = 16;
  localparam int unsigned ExamW = 16;
  localparam int unsigned CntW  = 13;
  localparam int unsigned InMax = 65535;

  // controller -> datapath
  typedef struct packed {
    logic load;      // capture request, reset walk counter and prime count
    logic clr_wr;    // write 0 at walk address, advance
    logic p_init;    // p = 2
    logic p_rd;      // read map at p
    logic p_inc;     // p = p + 1
    logic m_init;    // m = p * p
    logic mark_wr;   // write 1 at m, m = m + p
    logic cnt_init;  // walk address = max(low, 2)
    logic cnt_rd;    // read map at walk address, advance
    logic out_load;  // move result into output register
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic err;
    logic clr_last;
    logic p_sq_gt;
    logic rd_bit;
    logic m_gt;
    logic v_gt;
    logic out_busy;
  } sts_t;

endpackage

@@ design/prc_req_if.sv @@
interface prc_req_if;
  logic                      valid;
  logic                      ready;
  logic [prc_pkg::InW-1:0]   range_low;
  logic [prc_pkg::InW-1:0]   range_high;

  modport source (output valid, range_low, range_high, input ready);
  modport sink   (input valid, range_low, range_high, output ready);
endinterface

@@ design/prc_rsp_if.sv @@
interface prc_rsp_if;
  logic                        valid;
  logic                        ready;
  logic [prc_pkg::ExamW-1:0]   examined_count;
  logic [prc_pkg::CntW-1:0]    prime_count;
  logic                        range_error;

  modport source (output valid, examined_count, prime_count, range_error, input ready);
  modport sink   (input valid, examined_count, prime_count, range_error, output ready);
endinterface

@@ design/prc_ctrl.sv @@
module prc_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  prc_pkg::sts_t  sts_i,
  output prc_pkg::cmd_t  cmd_o
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_START,
    S_CLEAR,
    S_SIEVE_P,
    S_SIEVE_W,
    S_MARK,
    S_COUNT,
    S_DRAIN,
    S_DONE
  } state_e;

  state_e state_q, state_d;

  assign in_ready_o = (state_q == S_IDLE);

  always_comb begin
    cmd_o   = '0;
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = S_START;
        end
      end
      S_START: begin
        state_d = sts_i.err ? S_DONE : S_CLEAR;
      end
      S_CLEAR: begin
        cmd_o.clr_wr = 1'b1;
        if (sts_i.clr_last) begin
          cmd_o.p_init = 1'b1;
          state_d      = S_SIEVE_P;
        end
      end
      S_SIEVE_P: begin
        if (sts_i.p_sq_gt) begin
          cmd_o.cnt_init = 1'b1;
          state_d        = S_COUNT;
        end else begin
          cmd_o.p_rd = 1'b1;
          state_d    = S_SIEVE_W;
        end
      end
      S_SIEVE_W: begin
        if (sts_i.rd_bit) begin
          cmd_o.p_inc = 1'b1;
          state_d     = S_SIEVE_P;
        end else begin
          cmd_o.m_init = 1'b1;
          state_d      = S_MARK;
        end
      end
      S_MARK: begin
        if (sts_i.m_gt) begin
          cmd_o.p_inc = 1'b1;
          state_d     = S_SIEVE_P;
        end else begin
          cmd_o.mark_wr = 1'b1;
        end
      end
      S_COUNT: begin
        if (sts_i.v_gt) begin
          state_d = S_DRAIN;
        end else begin
          cmd_o.cnt_rd = 1'b1;
        end
      end
      S_DRAIN: begin
        state_d = S_DONE;
      end
      S_DONE: begin
        if (!sts_i.out_busy) begin
          cmd_o.out_load = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

@@ design/prc_dpath.sv @@
module prc_dpath #(
  parameter int unsigned MAX_VALUE = 65535
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  prc_pkg::cmd_t               cmd_i,
  output prc_pkg::sts_t               sts_o,
  input  logic [prc_pkg::InW-1:0]     range_low_i,
  input  logic [prc_pkg::InW-1:0]     range_high_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic [prc_pkg::ExamW-1:0]   examined_count_o,
  output logic [prc_pkg::CntW-1:0]    prime_count_o,
  output logic                        range_error_o
);

  localparam int unsigned Clamp = (MAX_VALUE < prc_pkg::InMax) ? MAX_VALUE : prc_pkg::InMax;
  localparam int unsigned AW    = $clog2(Clamp + 1);
  localparam int unsigned Depth = Clamp + 1;
  localparam int unsigned PW    = (AW + 1) / 2 + 1;
  localparam int unsigned SqW   = 2 * PW;
  localparam int unsigned DW    = prc_pkg::InW + 1;

  logic [prc_pkg::InW-1:0]   lo_clamp, hi_clamp;
  logic [DW-1:0]             diff;
  logic [AW-1:0]             lo_q, hi_q;
  logic                      err_q;
  logic [prc_pkg::ExamW-1:0] exam_q;
  logic [PW-1:0]             p_q;
  logic [SqW-1:0]            p_sq;
  logic [AW:0]               m_q, v_q;
  logic [prc_pkg::CntW-1:0]  count_q;
  logic                      pend_q;
  logic                      rd_q;

  logic                      map_q [Depth];
  logic                      map_we, map_wdata, map_re;
  logic [AW-1:0]             map_waddr, map_raddr;

  logic                      out_valid_q;
  logic [prc_pkg::ExamW-1:0] out_exam_q;
  logic [prc_pkg::CntW-1:0]  out_count_q;
  logic                      out_err_q;

  assign lo_clamp = (range_low_i > prc_pkg::InW'(Clamp)) ? prc_pkg::InW'(Clamp) : range_low_i;
  assign hi_clamp = (range_high_i > prc_pkg::InW'(Clamp)) ? prc_pkg::InW'(Clamp) : range_high_i;
  assign diff     = {1'b0, hi_clamp} - {1'b0, lo_clamp} + DW'(1);

  assign p_sq = SqW'(p_q) * SqW'(p_q);

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      lo_q  <= lo_clamp[AW-1:0];
      hi_q  <= hi_clamp[AW-1:0];
      err_q <= (lo_clamp > hi_clamp);
      if (lo_clamp > hi_clamp) begin
        exam_q <= '0;
      end else if (diff[DW-1]) begin
        exam_q <= '1;
      end else begin
        exam_q <= diff[prc_pkg::ExamW-1:0];
      end
    end
    if (cmd_i.p_init) begin
      p_q <= PW'(2);
    end else if (cmd_i.p_inc) begin
      p_q <= p_q + PW'(1);
    end
    if (cmd_i.m_init) begin
      m_q <= (AW+1)'(p_sq);
    end else if (cmd_i.mark_wr) begin
      m_q <= m_q + (AW+1)'(p_q);
    end
    if (cmd_i.load) begin
      v_q <= '0;
    end else if (cmd_i.cnt_init) begin
      v_q <= (lo_q < AW'(2)) ? (AW+1)'(2) : {1'b0, lo_q};
    end else if (cmd_i.clr_wr || cmd_i.cnt_rd) begin
      v_q <= v_q + (AW+1)'(1);
    end
    if (cmd_i.load) begin
      count_q <= '0;
    end else if (pend_q && !rd_q) begin
      count_q <= count_q + prc_pkg::CntW'(1);
    end
  end

  // composite map, one access per cycle
  assign map_we    = cmd_i.clr_wr | cmd_i.mark_wr;
  assign map_wdata = cmd_i.mark_wr;
  assign map_waddr = cmd_i.mark_wr ? m_q[AW-1:0] : v_q[AW-1:0];
  assign map_re    = cmd_i.p_rd | cmd_i.cnt_rd;
  assign map_raddr = cmd_i.p_rd ? AW'(p_q) : v_q[AW-1:0];

  always_ff @(posedge clk_i) begin
    if (map_we) begin
      map_q[map_waddr] <= map_wdata;
    end
    if (map_re) begin
      rd_q <= map_q[map_raddr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      pend_q <= cmd_i.cnt_rd;
      if (cmd_i.out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      out_exam_q  <= exam_q;
      out_count_q <= err_q ? '0 : count_q;
      out_err_q   <= err_q;
    end
  end

  assign sts_o.err      = err_q;
  assign sts_o.clr_last = (v_q == {1'b0, hi_q});
  assign sts_o.p_sq_gt  = (p_sq > SqW'(hi_q));
  assign sts_o.rd_bit   = rd_q;
  assign sts_o.m_gt     = (m_q > {1'b0, hi_q});
  assign sts_o.v_gt     = (v_q > {1'b0, hi_q});
  assign sts_o.out_busy = out_valid_q & ~out_ready_i;

  assign out_valid_o      = out_valid_q;
  assign examined_count_o = out_exam_q;
  assign prime_count_o    = out_count_q;
  assign range_error_o    = out_err_q;

endmodule

@@ design/prime_range_counter.sv @@
// channel  dir  beat payload                                   handshake
// req      in   range_low[15:0], range_high[15:0]             valid/ready
// rsp      out  examined_count[15:0], prime_count[12:0],      valid/ready
//               range_error
//
// One request at a time; req.ready is high only while idle. A request with
// high >= low clears the map from 0 to high, reads it at each candidate p
// with p*p <= high, marks the multiples of each such p found prime from p*p
// up to high, and reads it from max(low,2) to high to count primes, all
// through the composite map. A low > high request skips these passes and
// answers with range_error. Reset clears control only; the map is cleared
// by the clear pass on each request. The result register lets a new request
// start while rsp is stalled; the next result waits until it is taken.
module prime_range_counter #(
  parameter int unsigned MAX_VALUE = 65535
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  prc_req_if.sink    req,
  prc_rsp_if.source  rsp
);

  prc_pkg::cmd_t cmd;
  prc_pkg::sts_t sts;

  prc_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (req.valid),
    .in_ready_o (req.ready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  prc_dpath #(
    .MAX_VALUE (MAX_VALUE)
  ) u_dpath (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .sts_o            (sts),
    .range_low_i      (req.range_low),
    .range_high_i     (req.range_high),
    .out_valid_o      (rsp.valid),
    .out_ready_i      (rsp.ready),
    .examined_count_o (rsp.examined_count),
    .prime_count_o    (rsp.prime_count),
    .range_error_o    (rsp.range_error)
  );

endmodule
